[src/fbap_pkg.sv]
// fbap_pkg: shared types and constants of the crate bank parser
`default_nettype none
package fbap_pkg;

	localparam logic [31:0] HDR_MASK = 32'hff0f_ff00;

	localparam int CRATE_W  = 4;
	localparam int SLOT_W   = 5;
	localparam int CHAN_W   = 6;
	localparam int VALUE_W  = 14;
	localparam int KIND_W   = 2;
	localparam int BOARDS_W = 8;
	localparam int BWORDS_W = 7;

	// configuration register indexes
	localparam logic REG_BEGIN_MARKER = 1'b0;
	localparam logic REG_END_MARKER   = 1'b1;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_HIT      = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BAD_HDR  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MISMATCH = 2'd2;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_SKIP   = 3'd1,
		PH_BOARD  = 3'd2,
		PH_DATA   = 3'd3,
		PH_IGNORE = 3'd4
	} phase_t;

	typedef struct packed {
		phase_t                phase;
		logic [CRATE_W-1:0]    crate_number;
		logic [BOARDS_W-1:0]   boards_left;
		logic [SLOT_W-1:0]     board_slot;
		logic [BWORDS_W-1:0]   board_words_left;
	} parse_state_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [CRATE_W-1:0] crate;
		logic [SLOT_W-1:0]  slot;
		logic [CHAN_W-1:0]  channel;
		logic [VALUE_W-1:0] value;
		logic [SLOT_W-1:0]  word_slot;
	} result_t;

endpackage
`default_nettype wire

[src/fbap_decode.sv]
// fbap_decode: next-state and result decode for one bank word
`default_nettype none
module fbap_decode (
	input  fbap_pkg::parse_state_t st,
	input  logic [31:0]            word,
	input  logic                   bank_last,
	input  logic [31:0]            begin_marker,
	input  logic [31:0]            end_marker,
	output fbap_pkg::parse_state_t nxt,
	output logic                   res_valid,
	output fbap_pkg::result_t      res
);

	logic [fbap_pkg::SLOT_W-1:0]   ws;
	logic [fbap_pkg::BWORDS_W-1:0] cnt;
	logic [fbap_pkg::BWORDS_W-1:0] bwl_new;
	logic [fbap_pkg::BOARDS_W-1:0] boards_dec;
	logic [fbap_pkg::BWORDS_W-1:0] bwl_dec;
	fbap_pkg::phase_t              after_board;

	assign ws         = word[31:27];
	assign cnt        = word[6:0];
	assign bwl_new    = (cnt > 7'd1) ? cnt - 7'd1 : '0;
	assign boards_dec = st.boards_left - 8'd1;
	assign bwl_dec    = st.board_words_left - 7'd1;
	assign after_board = (st.boards_left == '0) ? fbap_pkg::PH_IGNORE : fbap_pkg::PH_BOARD;

	always_comb begin
		nxt       = st;
		res_valid = 1'b0;
		res       = '0;
		unique case (st.phase)
			fbap_pkg::PH_HEADER: begin
				if ((word & fbap_pkg::HDR_MASK) != begin_marker) begin
					res_valid = 1'b1;
					res.kind  = fbap_pkg::KIND_BAD_HDR;
					res.crate = word[23:20];
					nxt.phase = fbap_pkg::PH_IGNORE;
				end else begin
					nxt.crate_number = word[23:20];
					nxt.boards_left  = word[7:0];
					nxt.phase        = fbap_pkg::PH_SKIP;
				end
			end
			fbap_pkg::PH_SKIP: nxt.phase = after_board;
			fbap_pkg::PH_BOARD: begin
				if (word == end_marker) begin
					nxt.phase = fbap_pkg::PH_IGNORE;
				end else begin
					nxt.board_slot       = ws;
					nxt.board_words_left = bwl_new;
					nxt.boards_left      = boards_dec;
					if (bwl_new == '0)
						nxt.phase = (boards_dec == '0) ? fbap_pkg::PH_IGNORE
							: fbap_pkg::PH_BOARD;
					else
						nxt.phase = fbap_pkg::PH_DATA;
				end
			end
			fbap_pkg::PH_DATA: begin
				res_valid     = 1'b1;
				res.crate     = st.crate_number;
				res.slot      = st.board_slot;
				res.word_slot = ws;
				if (ws == st.board_slot) begin
					res.kind    = fbap_pkg::KIND_HIT;
					res.channel = word[22:17];
					res.value   = word[13:0];
				end else begin
					res.kind = fbap_pkg::KIND_MISMATCH;
				end
				nxt.board_words_left = bwl_dec;
				if (bwl_dec == '0)
					nxt.phase = after_board;
			end
			default: nxt.phase = fbap_pkg::PH_IGNORE;
		endcase
		if (bank_last)
			nxt.phase = fbap_pkg::PH_HEADER;
	end

endmodule
`default_nettype wire

[src/fastbus_adc_bank_parser.sv]
// fastbus_adc_bank_parser: crate data bank word parser, top level
//
// channel  | handshake            | payload
// ---------+----------------------+----------------------------------------------
// in       | in_valid / in_stall  | word[31:0], bank_last
// out      | out_valid / out_stall| kind, crate, slot, channel, value, word_slot
// cfg      | cfg_we               | cfg_index (0 begin, 1 end marker), cfg_data
//
// one word per clock while out_stall is low; a word passes the input register, then the result register
// cost is set by one decode pass between the input register and the result register
// reset clears valid flags, parse phase and counters; markers reset to zero
// in_stall rises only while the input register is full and the result register
// is both full and stalled
`default_nettype none
module fastbus_adc_bank_parser (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	// input words
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] word,
	input  logic        bank_last,
	// results
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [3:0]  crate,
	output logic [4:0]  slot,
	output logic [5:0]  channel,
	output logic [13:0] value,
	output logic [4:0]  word_slot
);

	// configuration registers
	logic [31:0] begin_marker_q;
	logic [31:0] end_marker_q;

	// input register stage
	logic        valid_s1;
	logic [31:0] word_s1;
	logic        last_s1;

	// parse state, advanced as each word leaves stage 1
	fbap_pkg::parse_state_t state_q;
	fbap_pkg::parse_state_t state_nxt;

	// result register
	logic              out_valid_q;
	fbap_pkg::result_t res_q;
	fbap_pkg::result_t res_nxt;
	logic              res_valid_nxt;

	logic out_free;
	logic adv_s1;
	logic take_in;

	// result register can load when empty or draining this cycle
	assign out_free = !out_valid_q || !out_stall;
	// every word leaves stage 1 through the result register slot, hit or not
	assign adv_s1   = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign take_in  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			begin_marker_q <= '0;
			end_marker_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fbap_pkg::REG_BEGIN_MARKER: begin_marker_q <= cfg_data;
				fbap_pkg::REG_END_MARKER:   end_marker_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (take_in)
			valid_s1 <= 1'b1;
		else if (adv_s1)
			valid_s1 <= 1'b0;
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (take_in) begin
			word_s1 <= word;
			last_s1 <= bank_last;
		end
	end

	fbap_decode u_decode (
		.st           (state_q),
		.word         (word_s1),
		.bank_last    (last_s1),
		.begin_marker (begin_marker_q),
		.end_marker   (end_marker_q),
		.nxt          (state_nxt),
		.res_valid    (res_valid_nxt),
		.res          (res_nxt)
	);

	// parse state commits once per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase            <= fbap_pkg::PH_HEADER;
			state_q.crate_number     <= '0;
			state_q.boards_left      <= '0;
			state_q.board_slot       <= '0;
			state_q.board_words_left <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= adv_s1 && res_valid_nxt;
	end

	// result payload, held while stalled
	always_ff @(posedge clk) begin
		if (adv_s1 && res_valid_nxt)
			res_q <= res_nxt;
	end

	assign out_valid = out_valid_q;
	assign kind      = res_q.kind;
	assign crate     = res_q.crate;
	assign slot      = res_q.slot;
	assign channel   = res_q.channel;
	assign value     = res_q.value;
	assign word_slot = res_q.word_slot;

	// a bank's last word always returns the parser to expecting a crate header
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> (state_q.phase == fbap_pkg::PH_HEADER))
		else $error("phase not reset to header after bank last word");

	// a channel hit carries matching board and word slots
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.kind == fbap_pkg::KIND_HIT) |-> (res_q.slot == res_q.word_slot))
		else $error("channel hit with mismatched slot");

	// a new result only appears after a word sat in stage 1
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("result produced without a staged word");

	// input is held off only while stage 1 and the result register are both full
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q))
		else $error("input stalled with room in the pipeline");

endmodule
`default_nettype wire

[sim/tb.sv]
// tb: self-checking bench for the crate bank word parser, directed table then random banks
`timescale 1ns / 1ps
module tb;

	// consecutive cycles with no transaction on either side before the run is called hung
	localparam int QUIET_LIMIT   = 2000;
	// long receiver hold-off, long enough to back the block up to its input
	localparam int CHOKE_CYCLES  = 200;
	// a taken word still passes the input and result registers; words with no result need this margin
	localparam int SETTLE_CYCLES = 8;
	// keep a broken block from flooding the log
	localparam int MAX_REPORTS   = 40;

	// how a queued word is checked
	typedef enum logic [1:0] {
		CHK_MODEL,  // expectation from the predictor
		CHK_NONE,   // typed in: no result
		CHK_TYPED   // typed in: the result held in the row
	} chk_t;

	typedef struct {
		logic [31:0]       word;
		logic              last;
		chk_t              chk;
		fbap_pkg::result_t res;
	} bank_word_t;

	localparam fbap_pkg::result_t NO_RES = '0;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic        cfg_index = fbap_pkg::REG_BEGIN_MARKER;
	logic [31:0] cfg_data  = '0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [31:0] word      = '0;
	logic        bank_last = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  kind;
	logic [3:0]  crate;
	logic [4:0]  slot;
	logic [5:0]  channel;
	logic [13:0] value;
	logic [4:0]  word_slot;

	// words waiting to be offered, and reports the block still owes
	bank_word_t        word_feed [$];
	fbap_pkg::result_t pending_reports [$];
	bank_word_t        cur;
	int                err_count = 0;

	// idle mix, set per phase of the run
	int         src_gap_pct    = 0;
	int         sink_stall_pct = 0;
	logic       choke_req      = 1'b0;
	logic       choke_done     = 1'b0;
	int         choke_left     = 0;

	// parser state as the bench sees it, plus its copy of the markers
	fbap_pkg::phase_t              ph          = fbap_pkg::PH_HEADER;
	logic [fbap_pkg::CRATE_W-1:0]  cur_crate   = '0;
	logic [fbap_pkg::BOARDS_W-1:0] boards_todo = '0;
	logic [fbap_pkg::SLOT_W-1:0]   cur_slot    = '0;
	logic [fbap_pkg::BWORDS_W-1:0] words_todo  = '0;
	logic [31:0]                   begin_mark  = '0;
	logic [31:0]                   end_mark    = '0;

	// directed banks, run with the markers still at their reset value of zero
	bank_word_t dir_tab [23] = '{
		// crate 3 with three boards
		'{32'h0030_0003, 1'b0, CHK_NONE, NO_RES},
		// second word is skipped whatever it holds
		'{32'hffff_ffff, 1'b0, CHK_NONE, NO_RES},
		// board in slot 31, count 3: two data words
		'{32'hf800_0003, 1'b0, CHK_NONE, NO_RES},
		// all-ones channel and value
		'{32'hf87e_3fff, 1'b0, CHK_TYPED,
			'{fbap_pkg::KIND_HIT, 4'd3, 5'd31, 6'd63, 14'h3fff, 5'd31}},
		// slot 0 in a slot 31 board; a zero word is no end marker inside a board
		'{32'h0000_0000, 1'b0, CHK_TYPED,
			'{fbap_pkg::KIND_MISMATCH, 4'd3, 5'd31, 6'd0, 14'd0, 5'd0}},
		// count of one: header alone
		'{32'h0800_0001, 1'b0, CHK_NONE, NO_RES},
		// count of zero: header alone, last board
		'{32'h1000_0000, 1'b0, CHK_NONE, NO_RES},
		// word after the crate, closes the bank
		'{32'h1234_5678, 1'b1, CHK_NONE, NO_RES},
		// bad crate header
		'{32'hffff_ffff, 1'b0, CHK_TYPED,
			'{fbap_pkg::KIND_BAD_HDR, 4'd15, 5'd0, 6'd0, 14'd0, 5'd0}},
		'{32'h0000_0005, 1'b1, CHK_NONE, NO_RES},
		// crate with no boards ends on the skipped word
		'{32'h00f0_0000, 1'b0, CHK_NONE, NO_RES},
		'{32'h0000_0000, 1'b1, CHK_NONE, NO_RES},
		// end marker where the first board header should be
		'{32'h0050_0002, 1'b0, CHK_NONE, NO_RES},
		'{32'habcd_ef01, 1'b0, CHK_NONE, NO_RES},
		'{32'h0000_0000, 1'b0, CHK_NONE, NO_RES},
		'{32'h0000_0000, 1'b1, CHK_NONE, NO_RES},
		// 255 boards, first one of 127 words, cut short by the bank end
		'{32'h00a0_00ff, 1'b0, CHK_NONE, NO_RES},
		'{32'h0000_0000, 1'b0, CHK_NONE, NO_RES},
		'{32'h8000_007f, 1'b0, CHK_NONE, NO_RES},
		'{32'h8000_0000, 1'b0, CHK_TYPED,
			'{fbap_pkg::KIND_HIT, 4'd10, 5'd16, 6'd0, 14'd0, 5'd16}},
		'{32'h85a5_a5a5, 1'b1, CHK_MODEL, NO_RES},
		// bank of a single good header word
		'{32'h0010_0001, 1'b1, CHK_NONE, NO_RES},
		// bank of a single bad header word
		'{32'h8000_0000, 1'b1, CHK_TYPED,
			'{fbap_pkg::KIND_BAD_HDR, 4'd0, 5'd0, 6'd0, 14'd0, 5'd0}}
	};

	fastbus_adc_bank_parser u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.word      (word),
		.bank_last (bank_last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.crate     (crate),
		.slot      (slot),
		.channel   (channel),
		.value     (value),
		.word_slot (word_slot)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// step the parser state by one word; hit says whether a report comes out
	function automatic void parse_word(input logic [31:0] w, input logic last,
			output logic hit, output fbap_pkg::result_t r);
		hit = 1'b0;
		r   = '0;
		case (ph)
			fbap_pkg::PH_HEADER: begin
				if ((w & fbap_pkg::HDR_MASK) != begin_mark) begin
					hit     = 1'b1;
					r.kind  = fbap_pkg::KIND_BAD_HDR;
					r.crate = w[23:20];
					ph      = fbap_pkg::PH_IGNORE;
				end else begin
					cur_crate   = w[23:20];
					boards_todo = w[7:0];
					ph          = fbap_pkg::PH_SKIP;
				end
			end
			fbap_pkg::PH_SKIP: begin
				ph = (boards_todo == '0) ? fbap_pkg::PH_IGNORE : fbap_pkg::PH_BOARD;
			end
			fbap_pkg::PH_BOARD: begin
				if (w == end_mark) begin
					ph = fbap_pkg::PH_IGNORE;
				end else begin
					cur_slot    = w[31:27];
					words_todo  = (w[6:0] > 7'd1) ? w[6:0] - 7'd1 : '0;
					boards_todo = boards_todo - 8'd1;
					if (words_todo != '0)
						ph = fbap_pkg::PH_DATA;
					else
						ph = (boards_todo == '0) ? fbap_pkg::PH_IGNORE
							: fbap_pkg::PH_BOARD;
				end
			end
			fbap_pkg::PH_DATA: begin
				hit         = 1'b1;
				r.crate     = cur_crate;
				r.slot      = cur_slot;
				r.word_slot = w[31:27];
				if (w[31:27] == cur_slot) begin
					r.kind    = fbap_pkg::KIND_HIT;
					r.channel = w[22:17];
					r.value   = w[13:0];
				end else begin
					r.kind = fbap_pkg::KIND_MISMATCH;
				end
				words_todo = words_todo - 7'd1;
				if (words_todo == '0)
					ph = (boards_todo == '0) ? fbap_pkg::PH_IGNORE
						: fbap_pkg::PH_BOARD;
			end
			default: begin
				ph = fbap_pkg::PH_IGNORE;
			end
		endcase
		if (last)
			ph = fbap_pkg::PH_HEADER;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned seen);
		if (want != seen) begin
			if (err_count < MAX_REPORTS)
				$display("%0t %s mismatch: expected %0d, actual %0d",
					$time, name, want, seen);
			err_count++;
		end
	endfunction

	// sender, predictor and result check share one process so that a transaction
	// on the input and one on the output in the same edge are always seen in order
	always @(posedge clk) begin
		logic              hit;
		fbap_pkg::result_t r;
		if (arst_n) begin
			// input transaction: predict what it owes
			if (in_valid && !in_stall) begin
				parse_word(cur.word, cur.last, hit, r);
				if (cur.chk == CHK_TYPED)
					pending_reports.push_back(cur.res);
				else if (cur.chk == CHK_MODEL && hit)
					pending_reports.push_back(r);
			end
			// output transaction: compare with the oldest report owed
			if (out_valid && !out_stall) begin
				if (pending_reports.size() == 0) begin
					if (err_count < MAX_REPORTS)
						$display({"%0t unexpected result: expected none, actual kind %0d",
							" crate %0d slot %0d channel %0d value %0d word_slot %0d"},
							$time, kind, crate, slot, channel, value, word_slot);
					err_count++;
				end else begin
					r = pending_reports.pop_front();
					check_field("kind", r.kind, kind);
					check_field("crate", r.crate, crate);
					check_field("slot", r.slot, slot);
					check_field("channel", r.channel, channel);
					check_field("value", r.value, value);
					check_field("word_slot", r.word_slot, word_slot);
				end
			end
			// next word, held steady while stalled
			if (!in_valid || !in_stall) begin
				if (word_feed.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
					cur = word_feed.pop_front();
					in_valid  <= 1'b1;
					word      <= cur.word;
					bank_last <= cur.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stall, plus one long hold-off counted here
	always @(posedge clk) begin
		if (choke_req && !choke_done) begin
			choke_left = CHOKE_CYCLES;
			choke_done = 1'b1;
		end
		if (choke_left > 0) begin
			choke_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < sink_stall_pct);
		end
	end

	// watchdog on cycles with no transaction at all
	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("== FAIL ==");
		$finish;
	end

	// nothing left to send, nothing in flight on the input, nothing owed
	task automatic wait_drained();
		while (word_feed.size() != 0 || in_valid || pending_reports.size() != 0)
			@(posedge clk);
	endtask

	// marker writes only once the block has gone quiet
	task automatic write_markers(input logic [31:0] b, input logic [31:0] e);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= fbap_pkg::REG_BEGIN_MARKER;
		cfg_data  <= b;
		@(posedge clk);
		cfg_index <= fbap_pkg::REG_END_MARKER;
		cfg_data  <= e;
		@(posedge clk);
		cfg_we     <= 1'b0;
		begin_mark = b;
		end_mark   = e;
	endtask

	// random banks: mostly well-formed crates, some bad headers and loose noise
	task automatic queue_banks(input int n_words);
		logic [31:0] bank [$];
		logic [31:0] w;
		logic [4:0]  s;
		int          added, roll, nb, built, cnt, cut, b, d, i;
		added = 0;
		while (added < n_words) begin
			bank.delete();
			roll = $urandom_range(99);
			if (roll < 80) begin
				// crate header that matches the marker when the marker allows it
				w = (begin_mark & fbap_pkg::HDR_MASK) | ($urandom & ~fbap_pkg::HDR_MASK);
				nb = ($urandom_range(99) < 4) ? $urandom_range(7, 255) : $urandom_range(0, 4);
				w[7:0] = 8'(nb);
				bank.push_back(w);
				bank.push_back($urandom);
				// large board counts are closed early with the end marker
				built = (nb > 6) ? 6 : nb;
				for (b = 0; b < built; b++) begin
					if ($urandom_range(99) < 5)
						break;
					s = 5'($urandom);
					cnt = ($urandom_range(99) < 5) ? $urandom_range(8, 127) : $urandom_range(0, 7);
					w = $urandom;
					w[31:27] = s;
					w[6:0] = 7'(cnt);
					bank.push_back(w);
					for (d = 1; d < cnt; d++) begin
						w = $urandom;
						w[31:27] = ($urandom_range(99) < 90) ? s : s ^ 5'($urandom_range(1, 31));
						bank.push_back(w);
					end
				end
				if (b < nb)
					bank.push_back(end_mark);
				// trailing words that the block ignores
				repeat ($urandom_range(0, 2)) bank.push_back($urandom);
			end else if (roll < 90) begin
				w = $urandom;
				if ((w & fbap_pkg::HDR_MASK) == begin_mark)
					w ^= 32'h8000_0000;
				bank.push_back(w);
				repeat ($urandom_range(0, 3)) bank.push_back($urandom);
			end else begin
				// loose words, bank ends anywhere
				repeat ($urandom_range(1, 6)) begin
					word_feed.push_back(bank_word_t'{$urandom, ($urandom_range(99) < 25),
						CHK_MODEL, NO_RES});
					added++;
				end
			end
			if (bank.size() != 0) begin
				// now and then the bank ends in the middle of the crate
				cut = ($urandom_range(99) < 8) ? $urandom_range(0, bank.size() - 1)
					: bank.size() - 1;
				for (i = 0; i <= cut; i++)
					word_feed.push_back(bank_word_t'{bank[i], (i == cut), CHK_MODEL, NO_RES});
				added += cut + 1;
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// sender idles lightly, receiver stalls about half the time
		src_gap_pct    = 9;
		sink_stall_pct = 52;
		foreach (dir_tab[k]) word_feed.push_back(dir_tab[k]);

		// widest begin marker, all-ones end marker
		write_markers(32'hff0f_ff00, 32'hffff_ffff);
		queue_banks(250);
		write_markers($urandom & fbap_pkg::HDR_MASK, $urandom);
		queue_banks(150);

		// the other way round
		src_gap_pct    = 52;
		sink_stall_pct = 9;
		// begin marker no header can match: every crate header is bad
		write_markers(32'hffff_ffff, 32'h0000_0000);
		queue_banks(40);
		write_markers($urandom & fbap_pkg::HDR_MASK, $urandom);
		queue_banks(200);

		// no idling at all; one long hold-off fills the block up to its input
		src_gap_pct    = 0;
		sink_stall_pct = 0;
		write_markers($urandom & fbap_pkg::HDR_MASK, 32'h0000_0000);
		queue_banks(300);
		choke_req = 1'b1;

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0 && pending_reports.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[sim.f]
src/fbap_pkg.sv
src/fbap_decode.sv
src/fastbus_adc_bank_parser.sv
sim/tb.sv
